// ----- design/rsdp_pkg.sv -----
// ----------------------------------------------------------------------------
// rsdp_pkg: shared types and constants for the rod subset-sum engine.
// Holds the table entry layout, the reset contents and the item kinds.
// ----------------------------------------------------------------------------
package rsdp_pkg;

  localparam int WAYS_W = 32;
  localparam int FEW_W  = 11;
  localparam int COST_W = 32;
  localparam int TGT_W  = 11;
  localparam int ROD_W  = 16;

  localparam logic [FEW_W-1:0]  FEW_ALL_ONES  = {FEW_W{1'b1}};
  localparam logic [COST_W-1:0] COST_ALL_ONES = {COST_W{1'b1}};
  localparam logic [WAYS_W-1:0] WAYS_ALL_ONES = {WAYS_W{1'b1}};

  localparam logic KIND_ROD = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef struct packed {
    logic              reach;
    logic [WAYS_W-1:0] ways;
    logic [FEW_W-1:0]  fewest;
    logic [COST_W-1:0] cost;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_ORIGIN = '{
    reach:  1'b1,
    ways:   WAYS_W'(1),
    fewest: '0,
    cost:   '0
  };

  localparam entry_t ENTRY_EMPTY = '{
    reach:  1'b0,
    ways:   '0,
    fewest: FEW_ALL_ONES,
    cost:   COST_ALL_ONES
  };

endpackage

// ----- design/rsdp_ram.sv -----
// ----------------------------------------------------------------------------
// rsdp_ram: generic synchronous RAM.
// One write port and two read ports, with the read data registered.
// ----------------------------------------------------------------------------
module rsdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- design/rsdp_update.sv -----
// ----------------------------------------------------------------------------
// rsdp_update: one knapsack entry update.
// Combines the destination entry with the source entry shifted by one rod.
// ----------------------------------------------------------------------------
module rsdp_update (
  input  rsdp_pkg::entry_t                 src,
  input  rsdp_pkg::entry_t                 dst,
  input  logic [rsdp_pkg::ROD_W-1:0]       rod_cost,
  output rsdp_pkg::entry_t                 result
);

  logic [rsdp_pkg::WAYS_W:0]   ways_sum;
  logic [rsdp_pkg::COST_W:0]   cost_sum;
  logic [rsdp_pkg::WAYS_W-1:0] ways_sat;
  logic [rsdp_pkg::COST_W-1:0] cand_cost;
  logic [rsdp_pkg::FEW_W-1:0]  cand_few;

  always_comb begin
    ways_sum = {1'b0, dst.ways} + {1'b0, src.ways};
    ways_sat = ways_sum[rsdp_pkg::WAYS_W] ? rsdp_pkg::WAYS_ALL_ONES
                                          : ways_sum[rsdp_pkg::WAYS_W-1:0];
    cost_sum = {1'b0, src.cost}
             + {{(rsdp_pkg::COST_W + 1 - rsdp_pkg::ROD_W){1'b0}}, rod_cost};
    cand_cost = cost_sum[rsdp_pkg::COST_W] ? rsdp_pkg::COST_ALL_ONES
                                           : cost_sum[rsdp_pkg::COST_W-1:0];
    cand_few = (src.fewest == rsdp_pkg::FEW_ALL_ONES) ? rsdp_pkg::FEW_ALL_ONES
                                                      : src.fewest + 1'b1;
    result = dst;
    if (src.reach) begin
      result.reach  = 1'b1;
      result.ways   = ways_sat;
      result.fewest = (cand_few < dst.fewest) ? cand_few : dst.fewest;
      result.cost   = (cand_cost < dst.cost) ? cand_cost : dst.cost;
    end
  end

endmodule

// ----- design/rod_subset_sum_dp.sv -----
// ----------------------------------------------------------------------------
// rod_subset_sum_dp: four 0/1-knapsack tables held in one table RAM.
// Rod transfers update the entries from the target length down to the rod
// length; an end transfer reports the target entry and clears the tables.
// ----------------------------------------------------------------------------
// The update loop reads, modifies and writes one RAM entry per cycle.
// An end transfer reads the target entry in ST_RDT, registers the result in ST_RES, then clears the tables.
// Reset clears the tables with the same pass over every entry; no input
// transfer is taken during it, and the target register resets to zero.
module rod_subset_sum_dp #(
  parameter int MAX_LEN = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rsdp_pkg::TGT_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [rsdp_pkg::ROD_W-1:0]    rod_length,
  input  logic [rsdp_pkg::ROD_W-1:0]    rod_cost,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          feasible,
  output logic [rsdp_pkg::WAYS_W-1:0]   way_count,
  output logic [rsdp_pkg::FEW_W-1:0]    fewest_rods,
  output logic [rsdp_pkg::COST_W-1:0]   least_cost
);

  localparam int DEPTH = MAX_LEN + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = 17;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_LEN);
  localparam logic [LW-1:0] MAX_W    = LW'(MAX_LEN);

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_RUN  = 6'b000100,
    ST_WB   = 6'b001000,
    ST_RDT  = 6'b010000,
    ST_RES  = 6'b100000
  } state_t;

  state_t                       state;
  logic [rsdp_pkg::TGT_W-1:0]   target_length;
  logic [AW-1:0]                j;
  logic [AW-1:0]                len_r;
  logic [rsdp_pkg::ROD_W-1:0]   cost_r;
  logic                         end_ok;
  logic                         p_valid;
  logic [AW-1:0]                p_dst;

  logic                         in_accept;
  logic [LW-1:0]                tgt_w;
  logic [LW-1:0]                len_w;
  logic                         tgt_ok;
  logic                         rod_go;
  logic [AW-1:0]                src_addr;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  rsdp_pkg::entry_t             ram_wdata;
  rsdp_pkg::entry_t             rd_dst;
  rsdp_pkg::entry_t             rd_src;
  rsdp_pkg::entry_t             upd;
  logic                         out_load;
  logic                         res_feasible;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign tgt_w     = {{(LW - rsdp_pkg::TGT_W){1'b0}}, target_length};
  assign len_w     = {{(LW - rsdp_pkg::ROD_W){1'b0}}, rod_length};
  assign tgt_ok    = (tgt_w <= MAX_W);
  assign rod_go    = (rod_length != '0) && tgt_ok && (len_w <= tgt_w);
  assign src_addr  = j - len_r;

  always_comb begin
    if (state == ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = j;
      ram_wdata = (j == '0) ? rsdp_pkg::ENTRY_ORIGIN : rsdp_pkg::ENTRY_EMPTY;
    end else begin
      ram_we    = p_valid && rd_src.reach;
      ram_waddr = p_dst;
      ram_wdata = upd;
    end
  end

  rsdp_ram #(
    .WIDTH (rsdp_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (j),
    .rdata_a (rd_dst),
    .raddr_b (src_addr),
    .rdata_b (rd_src)
  );

  rsdp_update u_update (
    .src      (rd_src),
    .dst      (rd_dst),
    .rod_cost (cost_r),
    .result   (upd)
  );

  assign res_feasible = end_ok && rd_dst.reach;
  assign out_load     = (state == ST_RES) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_length <= '0;
    end else if (cfg_we) begin
      target_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      j       <= '0;
      p_valid <= 1'b0;
    end else begin
      p_valid <= (state == ST_RUN);
      p_dst   <= j;
      case (state)
        ST_CLR: begin
          if (j == LAST_IDX) begin
            state <= ST_IDLE;
          end else begin
            j <= j + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            if (kind == rsdp_pkg::KIND_END) begin
              end_ok <= tgt_ok;
              j      <= tgt_ok ? tgt_w[AW-1:0] : '0;
              state  <= ST_RDT;
            end else if (rod_go) begin
              j      <= tgt_w[AW-1:0];
              len_r  <= len_w[AW-1:0];
              cost_r <= rod_cost;
              state  <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (j == len_r) begin
            state <= ST_WB;
          end else begin
            j <= j - 1'b1;
          end
        end
        ST_WB: begin
          state <= ST_IDLE;
        end
        ST_RDT: begin
          state <= ST_RES;
        end
        ST_RES: begin
          if (out_load) begin
            j     <= '0;
            state <= ST_CLR;
          end
        end
        default: begin
          state <= ST_CLR;
          j     <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      feasible    <= res_feasible;
      way_count   <= res_feasible ? rd_dst.ways : '0;
      fewest_rods <= res_feasible ? rd_dst.fewest : '0;
      least_cost  <= res_feasible ? rd_dst.cost : '0;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (p_valid && state == ST_RUN) |-> (p_dst != j && p_dst != src_addr))
    else $error("Write-back collides with an entry being read.");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (j >= len_r))
    else $error("Update index fell below the rod length.");

  a_wb_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB) |-> p_valid)
    else $error("Final write-back missing.");

  a_end_read: assert property (@(posedge clk) disable iff (rst)
    (in_accept && kind == rsdp_pkg::KIND_END) |=> (state == ST_RDT))
    else $error("End transfer did not start the target read.");

  a_infeasible_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !feasible) |-> (way_count == '0 && fewest_rods == '0
                                  && least_cost == '0))
    else $error("Infeasible result carries nonzero fields.");

endmodule
